// ===== sv/flow_hash_table_counter_core_macros.svh =====
// Assertion macros for the flow hash table counter core.
// Included by fhtc_back, the RTL file that carries concurrent checks; no other dependencies.
`ifndef FLOW_HASH_TABLE_COUNTER_CORE_MACROS_SVH
`define FLOW_HASH_TABLE_COUNTER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, masked while reset is asserted.
`define FHTC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define FHTC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FHTC_ASSERT(lbl, clk, rst_n, prop, msg)
`define FHTC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/fhtc_pkg.sv =====
// Shared types and constants of the flow hash table counter core.
// No dependencies; imported by front, back and top level.
`default_nettype none

package fhtc_pkg;

    localparam int FHTC_TABLE_ENTRIES = 256;
    localparam int FHTC_QUEUE_DEPTH   = 2;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_CREATE = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] service_type;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] sequence_count;
    } t_out_item;

    typedef struct packed {
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] service_type;
    } t_key;

    typedef struct packed {
        t_key        key;
        logic [31:0] count;
    } t_entry;

endpackage

`default_nettype wire

// ===== sv/flow_hash_table_counter_core.sv =====
// Flow: the front hashes the key of one request at a time, while the back runs
// its one-read-per-probe loop over the table RAM for an earlier request; each
// part takes a new request only when it is through with the last one.
// Reset: synchronous, active low; afterwards the valid marks are cleared one slot a
// cycle, one pass over all TABLE_ENTRIES slots, during which o_in_stall is raised.
// Top level of the flow hash table counter; depends on fhtc_pkg, fhtc_front,
// fhtc_fifo, fhtc_back and fhtc_ram.
`default_nettype none

module flow_hash_table_counter_core
    import fhtc_pkg::*;
#(
    parameter int TABLE_ENTRIES = FHTC_TABLE_ENTRIES
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    // request channel
    input  wire logic      i_in_valid,
    input  wire t_in_item  i_in_item,
    output logic           o_in_stall,
    // result channel
    output logic           o_out_valid,
    output t_out_item      o_out_item,
    input  wire logic      i_out_stall
);

    // slot index width; also the probe counter width in the back
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int RW = $bits(t_in_item);
    // queue entry: home slot over the request
    localparam int QW = RW + IW;

    logic          w_clearing;
    logic          w_q_full;
    logic          w_push;
    t_in_item      w_push_item;
    logic [IW-1:0] w_push_home;
    logic [QW-1:0] w_push_data;
    logic          w_q_valid;
    logic          w_q_pop;
    logic [QW-1:0] w_q_data;
    t_in_item      w_q_item;
    logic [IW-1:0] w_q_home;

    // Front: one request at a time; the 32-bit OR of the key parts is reduced
    // modulo TABLE_ENTRIES a byte per cycle, the last byte at the queue push.
    fhtc_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .i_clearing  (w_clearing),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_push_item (w_push_item),
        .o_push_home (w_push_home)
    );

    assign w_push_data = {w_push_home, w_push_item};

    // Decoupling queue: the front keeps hashing while the back probes.
    fhtc_fifo #(
        .WIDTH (QW),
        .DEPTH (FHTC_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    assign w_q_item = t_in_item'(w_q_data[RW-1:0]);
    assign w_q_home = w_q_data[QW-1:RW];

    // Back: linear probing, one registered RAM read per probe; a lookup ends on an
    // empty slot or a key match, a create on the first empty slot, and either one
    // reports full after a whole pass. The result register parts it from the output.
    fhtc_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .i_q_home    (w_q_home),
        .o_q_pop     (w_q_pop),
        .o_clearing  (w_clearing),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

// ===== sv/fhtc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fhtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/fhtc_fifo.sv =====
// Short request queue between the front and the back of the core.
// No dependencies; width and depth come from the instantiating level.
`default_nettype none

module fhtc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

// ===== sv/fhtc_front.sv =====
// Front of the core: takes requests and reduces the key to its home slot.
// Depends on fhtc_pkg; feeds fhtc_fifo.
`default_nettype none

module fhtc_front
    import fhtc_pkg::*;
#(
    parameter int TABLE_ENTRIES = FHTC_TABLE_ENTRIES
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    input  wire t_in_item                         i_in_item,
    output logic                                  o_in_stall,
    input  wire logic                             i_clearing,
    input  wire logic                             i_q_full,
    output logic                                  o_push,
    output t_in_item                              o_push_item,
    output logic      [$clog2(TABLE_ENTRIES)-1:0] o_push_home
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam logic [IW:0] N_EXT = (IW + 1)'(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_HASH = 3'b010,
        F_PUSH = 3'b100
    } t_front_state;

    // One byte of a running remainder, MSB first: r = (r * 256 + b) mod N.
    function automatic logic [IW-1:0] f_mod_byte(input logic [IW-1:0] r,
                                                 input logic [7:0]    b);
        logic [IW:0] acc;
        acc = {1'b0, r};
        for (int k = 7; k >= 0; k--) begin
            acc = {acc[IW-1:0], b[k]};
            if (acc >= N_EXT) begin
                acc = acc - N_EXT;
            end
        end
        return acc[IW-1:0];
    endfunction

    t_front_state  r_state, n_state;
    logic          r_step, n_step;
    logic [IW-1:0] r_rem, n_rem;
    logic [23:0]   r_word, n_word;
    t_in_item      r_item, n_item;

    logic          w_can_take;
    logic          w_accept;
    logic [31:0]   w_word_in;

    assign w_word_in  = i_in_item.source_address | i_in_item.destination_address
                      | {16'd0, i_in_item.service_type};
    assign w_can_take = !i_clearing &&
                        ((r_state == F_IDLE) || ((r_state == F_PUSH) && !i_q_full));
    assign w_accept   = i_in_valid && w_can_take;
    assign o_in_stall = !w_can_take;

    assign o_push      = (r_state == F_PUSH) && !i_q_full;
    assign o_push_item = r_item;
    assign o_push_home = f_mod_byte(r_rem, r_word[7:0]);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_rem   = r_rem;
        n_word  = r_word;
        n_item  = r_item;
        unique case (r_state)
            F_IDLE: begin
            end
            F_HASH: begin
                n_rem  = f_mod_byte(r_rem, r_step ? r_word[15:8] : r_word[23:16]);
                n_step = 1'b1;
                if (r_step) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (o_push) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
        if (w_accept) begin
            n_item  = i_in_item;
            n_word  = w_word_in[23:0];
            n_rem   = f_mod_byte('0, w_word_in[31:24]);
            n_step  = 1'b0;
            n_state = F_HASH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_word <= n_word;
        r_item <= n_item;
    end

endmodule

`default_nettype wire

// ===== sv/fhtc_back.sv =====
// Back of the core: clears the valid marks, probes the table, writes entries.
// Depends on fhtc_pkg, fhtc_ram and the assertion macro header.
`default_nettype none
`include "flow_hash_table_counter_core_macros.svh"

module fhtc_back
    import fhtc_pkg::*;
#(
    parameter int TABLE_ENTRIES = FHTC_TABLE_ENTRIES
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_q_valid,
    input  wire t_in_item                         i_q_item,
    input  wire logic [$clog2(TABLE_ENTRIES)-1:0] i_q_home,
    output logic                                  o_q_pop,
    output logic                                  o_clearing,
    output logic                                  o_out_valid,
    output t_out_item                             o_out_item,
    input  wire logic                             i_out_stall
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_ENTRIES - 1);

    typedef enum logic [2:0] {
        B_CLEAR = 3'b001,
        B_IDLE  = 3'b010,
        B_CHECK = 3'b100
    } t_back_state;

    t_back_state   r_state, n_state;
    logic [IW-1:0] r_clr_addr, n_clr_addr;
    t_in_item      r_item, n_item;
    logic [IW-1:0] r_slot, n_slot;
    logic [IW-1:0] r_probes, n_probes;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out, n_out;

    logic          w_start, w_out_take, w_check, w_create;
    logic          w_empty, w_hit, w_last, w_done;
    logic [IW-1:0] w_next_slot, w_rd_addr;
    logic          w_re;
    logic          w_vld_we;
    logic [IW-1:0] w_vld_waddr;
    logic [0:0]    w_vld_wdata, w_vld_q;
    logic          w_ent_we;
    t_entry        w_ent_wdata, w_entry_q;
    logic [$bits(t_entry)-1:0] w_ent_rdata;
    t_key          w_req_key;
    logic [31:0]   w_count_inc;
    t_out_item     w_result;

    assign w_out_take = r_out_valid && !i_out_stall;
    // start only with the result register free or emptied in this cycle, so a finished probe never waits
    assign w_start    = (r_state == B_IDLE) && i_q_valid && (!r_out_valid || !i_out_stall);
    assign w_check    = (r_state == B_CHECK);
    assign w_create   = (r_item.mode == MODE_CREATE);

    assign w_req_key  = {r_item.source_address, r_item.destination_address,
                         r_item.service_type};
    assign w_entry_q  = t_entry'(w_ent_rdata);
    assign w_empty    = !w_vld_q[0];
    assign w_hit      = !w_create && w_vld_q[0] && (w_entry_q.key == w_req_key);
    assign w_last     = (r_probes == LAST_SLOT);
    assign w_done     = w_empty || w_hit || w_last;
    assign w_count_inc = w_entry_q.count + 32'd1;

    assign w_next_slot = (r_slot == LAST_SLOT) ? '0 : r_slot + IW'(1);
    assign w_rd_addr   = (r_state == B_IDLE) ? i_q_home : w_next_slot;
    assign w_re        = w_start || (w_check && !w_done);

    assign w_vld_we    = (r_state == B_CLEAR) || (w_check && w_empty && w_create);
    assign w_vld_waddr = (r_state == B_CLEAR) ? r_clr_addr : r_slot;
    assign w_vld_wdata = (r_state == B_CLEAR) ? 1'b0 : 1'b1;

    assign w_ent_we          = w_check && ((w_empty && w_create) || w_hit);
    assign w_ent_wdata.key   = w_req_key;
    assign w_ent_wdata.count = w_create ? 32'd0 : w_count_inc;

    always_comb begin
        w_result.sequence_count = 32'd0;
        if (w_empty) begin
            w_result.status = w_create ? ST_OK : ST_MISS;
        end else if (w_hit) begin
            w_result.status         = ST_OK;
            w_result.sequence_count = w_count_inc;
        end else begin
            w_result.status = ST_FULL;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_item      = r_item;
        n_slot      = r_slot;
        n_probes    = r_probes;
        n_out_valid = r_out_valid && !w_out_take;
        n_out       = r_out;
        unique case (r_state)
            B_CLEAR: begin
                n_clr_addr = r_clr_addr + IW'(1);
                if (r_clr_addr == LAST_SLOT) begin
                    n_clr_addr = '0;
                    n_state    = B_IDLE;
                end
            end
            B_IDLE: begin
                if (w_start) begin
                    n_item   = i_q_item;
                    n_slot   = i_q_home;
                    n_probes = '0;
                    n_state  = B_CHECK;
                end
            end
            B_CHECK: begin
                if (w_done) begin
                    n_out_valid = 1'b1;
                    n_out       = w_result;
                    n_state     = B_IDLE;
                end else begin
                    n_slot   = w_next_slot;
                    n_probes = r_probes + IW'(1);
                end
            end
            default: begin
                n_state = B_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_slot   <= n_slot;
        r_probes <= n_probes;
        r_out    <= n_out;
    end

    fhtc_ram #(
        .WIDTH (1),
        .DEPTH (TABLE_ENTRIES)
    ) u_valid_ram (
        .i_clk   (i_clk),
        .i_we    (w_vld_we),
        .i_waddr (w_vld_waddr),
        .i_wdata (w_vld_wdata),
        .i_re    (w_re),
        .i_raddr (w_rd_addr),
        .o_rdata (w_vld_q)
    );

    fhtc_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_ent_we),
        .i_waddr (r_slot),
        .i_wdata (w_ent_wdata),
        .i_re    (w_re),
        .i_raddr (w_rd_addr),
        .o_rdata (w_ent_rdata)
    );

    assign o_q_pop     = w_start;
    assign o_clearing  = (r_state == B_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `FHTC_ASSERT(a_result_from_check, i_clk, i_rst_n,
        $rose(r_out_valid) |-> $past(r_state == B_CHECK), "result not from a probe")
    `FHTC_ASSERT(a_no_overwrite, i_clk, i_rst_n,
        (r_state == B_CHECK) |-> !r_out_valid, "probe running over a pending result")
    `FHTC_ASSERT(a_clear_full_pass, i_clk, i_rst_n,
        $fell(o_clearing) |-> ($past(r_clr_addr) == LAST_SLOT), "clear pass cut short")
    `FHTC_ASSERT_ALWAYS(a_no_pop_in_clear, i_clk,
        (r_state == B_CLEAR) |-> (!o_q_pop && !w_ent_we), "table access during clear")

endmodule

`default_nettype wire
